[sv/assert_macros.svh]
// Assertion macros used by the checker file of the tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ALT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ALT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/alt_pkg.sv]
// Shared types and constants of the assembly line tokenizer.
package alt_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    // Depth of the result queue; a character may add two results.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_ADDR  = 2'd0;
    localparam logic [1:0] KIND_COMP  = 2'd1;
    localparam logic [1:0] KIND_LABEL = 2'd2;

    localparam logic [2:0] ERR_OK            = 3'd0;
    localparam logic [2:0] ERR_LONE_SLASH    = 3'd1;
    localparam logic [2:0] ERR_BAD_CHAR      = 3'd2;
    localparam logic [2:0] ERR_EMPTY_OPERAND = 3'd3;
    localparam logic [2:0] ERR_BAD_LABEL     = 3'd4;
    localparam logic [2:0] ERR_NO_CLOSE      = 3'd5;
    localparam logic [2:0] ERR_EMPTY_COMP    = 3'd6;
    localparam logic [2:0] ERR_SHORT_JUMP    = 3'd7;

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_M   = 8'h4D;
    localparam logic [7:0] CH_UP_D   = 8'h44;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    localparam logic [1:0] JUMP_CHARS = 2'd3;

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_SLASH,
        SCAN_COMMENT,
        SCAN_A_FIRST,
        SCAN_A_DEC,
        SCAN_A_SYM,
        SCAN_L_FIRST,
        SCAN_L_SYM,
        SCAN_C_PART1,
        SCAN_C_COMP,
        SCAN_C_JUMP
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] character;
        logic       final_char;
    } t_in;

    typedef struct packed {
        logic [1:0]  command_kind;
        logic [15:0] symbol_offset;
        logic [15:0] symbol_length;
        logic [15:0] dest_offset;
        logic [15:0] dest_length;
        logic [15:0] comp_offset;
        logic [15:0] comp_length;
        logic [15:0] jump_offset;
        logic        jump_present;
        logic [2:0]  error_code;
        logic [15:0] error_offset;
        logic        last_result;
    } t_out;

    // Results of one character, in order, and how many of them are real.
    typedef struct packed {
        t_out [1:0] res;
        logic [1:0] count;
    } t_scan_res;

endpackage

[sv/alt_scan.sv]
// Character scanner: tokenizer state and the results caused by one character.
module alt_scan #(
    parameter int OFFSET_BITS = alt_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_proc,
    input  alt_pkg::t_in      i_in,
    output alt_pkg::t_scan_res o_res
);

    typedef logic [OFFSET_BITS-1:0] t_off;

    typedef struct packed {
        t_off ps;
        t_off pl;
        t_off sds;
        t_off sdl;
        t_off scs;
        t_off scl;
    } t_snap;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_ADDR,
        EM_LABEL,
        EM_COMP,
        EM_JUMP,
        EM_FAIL
    } t_emit_kind;

    typedef struct packed {
        t_emit_kind kind;
        logic [2:0] err;
    } t_emit;

    localparam t_off LEN_MAX = {OFFSET_BITS{1'b1}};

    alt_pkg::t_scan_mode r_mode, n_mode;
    t_off       r_pos, n_pos;
    t_off       r_ps, n_ps;
    t_off       r_pl, n_pl;
    t_off       r_sds, n_sds;
    t_off       r_sdl, n_sdl;
    t_off       r_scs, n_scs;
    t_off       r_scl, n_scl;
    logic [1:0] r_jc, n_jc;
    logic       r_halted, n_halted;

    t_emit      em_take, em_idle, em_close;
    t_snap      snap_take, snap_close;
    logic [7:0] c;
    t_off       pos_inc;

    function automatic logic is_digit(logic [7:0] ch);
        return ch >= alt_pkg::CH_ZERO && ch <= alt_pkg::CH_NINE;
    endfunction

    function automatic logic is_sym(logic [7:0] ch);
        return (ch >= alt_pkg::CH_UP_A && ch <= alt_pkg::CH_UP_Z)
            || (ch >= alt_pkg::CH_LOW_A && ch <= alt_pkg::CH_LOW_Z)
            || is_digit(ch) || ch == alt_pkg::CH_UNDER || ch == alt_pkg::CH_DOT
            || ch == alt_pkg::CH_DOLLAR || ch == alt_pkg::CH_COLON;
    endfunction

    function automatic logic is_blank(logic [7:0] ch);
        return ch == alt_pkg::CH_TAB || ch == alt_pkg::CH_LF
            || ch == alt_pkg::CH_CR || ch == alt_pkg::CH_SPACE;
    endfunction

    function automatic logic is_comp_start(logic [7:0] ch);
        return ch == alt_pkg::CH_ZERO || ch == alt_pkg::CH_ONE || ch == alt_pkg::CH_UP_A
            || ch == alt_pkg::CH_UP_M || ch == alt_pkg::CH_UP_D
            || ch == alt_pkg::CH_MINUS || ch == alt_pkg::CH_BANG;
    endfunction

    function automatic logic is_comp(logic [7:0] ch);
        return is_comp_start(ch) || ch == alt_pkg::CH_PLUS || ch == alt_pkg::CH_AMP
            || ch == alt_pkg::CH_BAR;
    endfunction

    function automatic t_off grow(t_off len);
        return (len != LEN_MAX) ? t_off'(len + 1'b1) : len;
    endfunction

    function automatic alt_pkg::t_out fmt(t_emit em, t_snap s, t_off eoff);
        alt_pkg::t_out r;
        r = '0;
        case (em.kind)
            EM_ADDR, EM_LABEL: begin
                r.command_kind  = (em.kind == EM_ADDR) ? alt_pkg::KIND_ADDR
                                                       : alt_pkg::KIND_LABEL;
                r.symbol_offset = 16'(s.ps);
                r.symbol_length = 16'(s.pl);
            end
            EM_COMP, EM_JUMP: begin
                r.command_kind = alt_pkg::KIND_COMP;
                r.dest_offset  = 16'(s.sds);
                r.dest_length  = 16'(s.sdl);
                r.comp_offset  = 16'(s.scs);
                r.comp_length  = 16'(s.scl);
                if (em.kind == EM_JUMP) begin
                    r.jump_offset  = 16'(s.ps);
                    r.jump_present = 1'b1;
                end
            end
            EM_FAIL: begin
                r.error_code   = em.err;
                r.error_offset = 16'(eoff);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    assign c       = i_in.character;
    assign pos_inc = t_off'(r_pos + 1'b1);

    always_comb begin : next_state
        logic run_idle;
        run_idle   = 1'b0;
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_ps       = r_ps;
        n_pl       = r_pl;
        n_sds      = r_sds;
        n_sdl      = r_sdl;
        n_scs      = r_scs;
        n_scl      = r_scl;
        n_jc       = r_jc;
        n_halted   = r_halted;
        em_take    = '{EM_NONE, alt_pkg::ERR_OK};
        em_idle    = '{EM_NONE, alt_pkg::ERR_OK};
        em_close   = '{EM_NONE, alt_pkg::ERR_OK};
        snap_take  = '{r_ps, r_pl, r_sds, r_sdl, r_scs, r_scl};
        snap_close = snap_take;

        if (!r_halted) begin
            unique case (r_mode) inside
                alt_pkg::SCAN_SLASH: begin
                    if (c == alt_pkg::CH_SLASH) begin
                        n_mode = alt_pkg::SCAN_COMMENT;
                    end else begin
                        em_take  = '{EM_FAIL, alt_pkg::ERR_LONE_SLASH};
                        n_halted = 1'b1;
                        n_mode   = alt_pkg::SCAN_IDLE;
                    end
                end
                alt_pkg::SCAN_COMMENT: begin
                    if (c == alt_pkg::CH_LF) begin
                        n_mode = alt_pkg::SCAN_IDLE;
                    end
                end
                alt_pkg::SCAN_A_FIRST: begin
                    if (is_digit(c)) begin
                        n_mode = alt_pkg::SCAN_A_DEC;
                        n_pl   = t_off'(1);
                    end else if (is_sym(c)) begin
                        n_mode = alt_pkg::SCAN_A_SYM;
                        n_pl   = t_off'(1);
                    end else begin
                        em_take  = '{EM_FAIL, alt_pkg::ERR_EMPTY_OPERAND};
                        n_halted = 1'b1;
                        n_mode   = alt_pkg::SCAN_IDLE;
                    end
                end
                alt_pkg::SCAN_A_DEC, alt_pkg::SCAN_A_SYM: begin
                    if ((r_mode == alt_pkg::SCAN_A_DEC) ? is_digit(c) : is_sym(c)) begin
                        n_pl = grow(r_pl);
                    end else begin
                        em_take  = '{EM_ADDR, alt_pkg::ERR_OK};
                        n_mode   = alt_pkg::SCAN_IDLE;
                        run_idle = 1'b1;
                    end
                end
                alt_pkg::SCAN_L_FIRST: begin
                    if (is_sym(c) && !is_digit(c)) begin
                        n_mode = alt_pkg::SCAN_L_SYM;
                        n_pl   = t_off'(1);
                    end else begin
                        em_take  = '{EM_FAIL, alt_pkg::ERR_BAD_LABEL};
                        n_halted = 1'b1;
                        n_mode   = alt_pkg::SCAN_IDLE;
                    end
                end
                alt_pkg::SCAN_L_SYM: begin
                    if (is_sym(c)) begin
                        n_pl = grow(r_pl);
                    end else if (c == alt_pkg::CH_RPAREN) begin
                        em_take = '{EM_LABEL, alt_pkg::ERR_OK};
                        n_mode  = alt_pkg::SCAN_IDLE;
                    end else begin
                        em_take  = '{EM_FAIL, alt_pkg::ERR_NO_CLOSE};
                        n_halted = 1'b1;
                        n_mode   = alt_pkg::SCAN_IDLE;
                    end
                end
                alt_pkg::SCAN_C_PART1: begin
                    if (is_comp(c)) begin
                        n_pl = grow(r_pl);
                    end else if (c == alt_pkg::CH_EQUALS) begin
                        n_sds  = r_ps;
                        n_sdl  = r_pl;
                        n_ps   = pos_inc;
                        n_pl   = '0;
                        n_mode = alt_pkg::SCAN_C_COMP;
                    end else begin
                        // Without '=' the first part was the computation.
                        n_sds = '0;
                        n_sdl = '0;
                        n_scs = r_ps;
                        n_scl = r_pl;
                        if (c == alt_pkg::CH_SEMI) begin
                            n_ps   = pos_inc;
                            n_jc   = '0;
                            n_mode = alt_pkg::SCAN_C_JUMP;
                        end else begin
                            em_take  = '{EM_COMP, alt_pkg::ERR_OK};
                            n_mode   = alt_pkg::SCAN_IDLE;
                            run_idle = 1'b1;
                        end
                    end
                end
                alt_pkg::SCAN_C_COMP: begin
                    if (is_comp(c)) begin
                        n_pl = grow(r_pl);
                    end else if (r_pl == '0) begin
                        em_take  = '{EM_FAIL, alt_pkg::ERR_EMPTY_COMP};
                        n_halted = 1'b1;
                        n_mode   = alt_pkg::SCAN_IDLE;
                    end else begin
                        n_scs = r_ps;
                        n_scl = r_pl;
                        if (c == alt_pkg::CH_SEMI) begin
                            n_ps   = pos_inc;
                            n_jc   = '0;
                            n_mode = alt_pkg::SCAN_C_JUMP;
                        end else begin
                            em_take  = '{EM_COMP, alt_pkg::ERR_OK};
                            n_mode   = alt_pkg::SCAN_IDLE;
                            run_idle = 1'b1;
                        end
                    end
                end
                alt_pkg::SCAN_C_JUMP: begin
                    n_jc = r_jc + 2'd1;
                    if (n_jc == alt_pkg::JUMP_CHARS) begin
                        em_take = '{EM_JUMP, alt_pkg::ERR_OK};
                        n_mode  = alt_pkg::SCAN_IDLE;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase

            snap_take = '{n_ps, n_pl, n_sds, n_sdl, n_scs, n_scl};

            // A character that ended an address or computation command, or met in idle, is scanned as a new start.
            if (run_idle) begin
                if (c == alt_pkg::CH_AT || c == alt_pkg::CH_LPAREN) begin
                    n_mode = (c == alt_pkg::CH_AT) ? alt_pkg::SCAN_A_FIRST
                                                   : alt_pkg::SCAN_L_FIRST;
                    n_ps   = pos_inc;
                    n_pl   = '0;
                end else if (c == alt_pkg::CH_SLASH) begin
                    n_mode = alt_pkg::SCAN_SLASH;
                end else if (is_blank(c)) begin
                    n_mode = alt_pkg::SCAN_IDLE;
                end else if (is_comp_start(c)) begin
                    n_mode = alt_pkg::SCAN_C_PART1;
                    n_ps   = r_pos;
                    n_pl   = t_off'(1);
                end else if (is_sym(c)) begin
                    em_idle  = '{EM_FAIL, alt_pkg::ERR_EMPTY_COMP};
                    n_halted = 1'b1;
                    n_mode   = alt_pkg::SCAN_IDLE;
                end else begin
                    em_idle  = '{EM_FAIL, alt_pkg::ERR_BAD_CHAR};
                    n_halted = 1'b1;
                    n_mode   = alt_pkg::SCAN_IDLE;
                end
            end
        end

        if (i_in.final_char) begin
            snap_close = '{n_ps, n_pl, n_sds, n_sdl, n_scs, n_scl};
            if (!n_halted) begin
                unique case (n_mode) inside
                    alt_pkg::SCAN_SLASH:
                        em_close = '{EM_FAIL, alt_pkg::ERR_LONE_SLASH};
                    alt_pkg::SCAN_A_FIRST:
                        em_close = '{EM_FAIL, alt_pkg::ERR_EMPTY_OPERAND};
                    alt_pkg::SCAN_A_DEC, alt_pkg::SCAN_A_SYM:
                        em_close = '{EM_ADDR, alt_pkg::ERR_OK};
                    alt_pkg::SCAN_L_FIRST:
                        em_close = '{EM_FAIL, alt_pkg::ERR_BAD_LABEL};
                    alt_pkg::SCAN_L_SYM:
                        em_close = '{EM_FAIL, alt_pkg::ERR_NO_CLOSE};
                    alt_pkg::SCAN_C_PART1: begin
                        snap_close.sds = '0;
                        snap_close.sdl = '0;
                        snap_close.scs = n_ps;
                        snap_close.scl = n_pl;
                        em_close       = '{EM_COMP, alt_pkg::ERR_OK};
                    end
                    alt_pkg::SCAN_C_COMP: begin
                        if (n_pl == '0) begin
                            em_close = '{EM_FAIL, alt_pkg::ERR_EMPTY_COMP};
                        end else begin
                            snap_close.scs = n_ps;
                            snap_close.scl = n_pl;
                            em_close       = '{EM_COMP, alt_pkg::ERR_OK};
                        end
                    end
                    alt_pkg::SCAN_C_JUMP:
                        em_close = '{EM_FAIL, alt_pkg::ERR_SHORT_JUMP};
                    default: begin
                    end
                endcase
            end
            // The next character starts a fresh text.
            n_mode   = alt_pkg::SCAN_IDLE;
            n_pos    = '0;
            n_ps     = '0;
            n_pl     = '0;
            n_sds    = '0;
            n_sdl    = '0;
            n_scs    = '0;
            n_scl    = '0;
            n_jc     = '0;
            n_halted = 1'b0;
        end else begin
            n_pos = pos_inc;
        end
    end

    always_comb begin : results
        alt_pkg::t_out f_take;
        alt_pkg::t_out f_idle;
        alt_pkg::t_out f_close;
        logic [1:0]    cnt;
        f_take  = fmt(em_take, snap_take, r_pos);
        f_idle  = fmt(em_idle, snap_take, r_pos);
        f_close = fmt(em_close, snap_close, pos_inc);
        o_res   = '0;
        cnt     = '0;
        if (em_take.kind != EM_NONE) begin
            o_res.res[cnt[0]] = f_take;
            cnt = cnt + 2'd1;
        end
        if (em_idle.kind != EM_NONE) begin
            o_res.res[cnt[0]] = f_idle;
            cnt = cnt + 2'd1;
        end
        if (em_close.kind != EM_NONE) begin
            o_res.res[cnt[0]] = f_close;
            cnt = cnt + 2'd1;
        end
        o_res.res[0].last_result = (cnt == 2'd1);
        o_res.res[1].last_result = 1'b1;
        o_res.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= alt_pkg::SCAN_IDLE;
            r_pos    <= '0;
            r_ps     <= '0;
            r_pl     <= '0;
            r_sds    <= '0;
            r_sdl    <= '0;
            r_scs    <= '0;
            r_scl    <= '0;
            r_jc     <= '0;
            r_halted <= 1'b0;
        end else if (i_proc) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_ps     <= n_ps;
            r_pl     <= n_pl;
            r_sds    <= n_sds;
            r_sdl    <= n_sdl;
            r_scs    <= n_scs;
            r_scl    <= n_scl;
            r_jc     <= n_jc;
            r_halted <= n_halted;
        end
    end

endmodule

[sv/alt_out_queue.sv]
// Result queue: takes up to two results a cycle and hands out one when not stalled.
module alt_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  alt_pkg::t_scan_res i_push,
    input  logic               i_stall,
    output logic               o_valid,
    output alt_pkg::t_out      o_data,
    output logic               o_room
);

    localparam int PW = alt_pkg::QUEUE_PTR_BITS;
    localparam int CW = alt_pkg::QUEUE_CNT_BITS;

    alt_pkg::t_out r_mem [alt_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_rd, n_rd;
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] wr_second;
    logic [CW-1:0] r_count, n_count;
    logic          pop;

    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd];
    // Room for the two results that one request may produce.
    assign o_room    = (r_count <= CW'(alt_pkg::QUEUE_DEPTH - 2));
    assign pop       = o_valid && !i_stall;
    assign wr_second = PW'(r_wr + 1'b1);
    assign n_wr      = PW'(r_wr + PW'(i_push.count));
    assign n_rd      = PW'(r_rd + PW'(pop));
    assign n_count   = CW'(r_count + CW'(i_push.count) - CW'(pop));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res[0];
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_second] <= i_push.res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_count <= n_count;
        end
    end

endmodule

[sv/assembly_line_tokenizer_top.sv]
// Assembly line tokenizer top level: one source character in, command results out.
// One character is taken per clock cycle while o_stall is low. A request is held
// in the input register, scanned against the tokenizer state once the queue has
// room, and its results land in a four-entry result queue, from which the result
// port offers them. Most characters produce no result or one; a character that
// both ends a command and starts a bad one, or ends the text, can produce two,
// and the result port then hands them out one after the other, which the queue
// absorbs. Input stall rises only when the queue holds more than two results that
// the receiver has not yet taken. Offsets count from 0 at the start of each text
// and the state returns to its reset values after the final character.
module assembly_line_tokenizer_top #(
    parameter int OFFSET_BITS = alt_pkg::OFFSET_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  alt_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output alt_pkg::t_out o_out
);

    logic               r_in_valid, n_in_valid;
    alt_pkg::t_in       r_in;
    logic               room;
    logic               proc;
    logic               accept;
    alt_pkg::t_scan_res scan_res;
    alt_pkg::t_scan_res push;

    assign proc    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (proc) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        push = scan_res;
        if (!proc) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
    end

    alt_scan #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_proc (proc),
        .i_in   (r_in),
        .o_res  (scan_res)
    );

    alt_out_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_stall(i_stall),
        .o_valid(o_valid),
        .o_data (o_out),
        .o_room (room)
    );

endmodule

[sv/alt_checker.sv]
// Port checker for the assembly line tokenizer, bound to the top level.
`include "assert_macros.svh"

module alt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          i_in_stall,
    input alt_pkg::t_in  i_in,
    input logic          i_out_valid,
    input logic          i_stall,
    input alt_pkg::t_out i_out
);

    // A stalled request stays offered with the same character.
    `ALT_ASSERT(a_in_hold, i_clk, i_rst_n, i_valid && i_in_stall |=> i_valid && $stable(i_in), "stalled request changed")

    // A result offered under stall is still offered in the next cycle.
    `ALT_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_stall |=> i_out_valid, "result dropped under stall")

    // A stalled result keeps its contents.
    `ALT_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_stall |=> $stable(i_out), "stalled result changed")

    // Reset empties both the input register and the result queue.
    `ALT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid && !i_in_stall, "not empty after reset")

    // An error result carries no command and is the last one of its request.
    `ALT_ASSERT(a_error_last, i_clk, i_rst_n, i_out_valid && (i_out.error_code != alt_pkg::ERR_OK) |-> i_out.last_result && (i_out.command_kind == alt_pkg::KIND_ADDR), "malformed error result")

endmodule

bind assembly_line_tokenizer_top alt_checker u_alt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .i_in_stall (o_stall),
    .i_in       (i_in),
    .i_out_valid(o_valid),
    .i_stall    (i_stall),
    .i_out      (o_out)
);
